### sv/clipped_rect_blit_row_generator_unit_assert.svh
// Assertion macros for the blit row generator.
`ifndef CLIPPED_RECT_BLIT_ROW_GENERATOR_UNIT_ASSERT_SVH
`define CLIPPED_RECT_BLIT_ROW_GENERATOR_UNIT_ASSERT_SVH

// cond holds at every edge outside reset
`define CRBRG_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("invariant violated");

// cons holds in the same cycle as ante
`define CRBRG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");

// cons holds in the cycle after ante
`define CRBRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

### sv/crbrg_pkg.sv
`default_nettype none
package crbrg_pkg;

	localparam int MAX_DIM_DEF = 4096;
	localparam int Q_DEPTH_DEF = 8;
	localparam int CW          = 16;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH  = 2'd3;

	localparam logic [31:0] RST_BASE   = 32'd0;
	localparam logic [12:0] RST_WIDTH  = 13'd640;
	localparam logic [12:0] RST_HEIGHT = 13'd480;
	localparam logic [15:0] RST_PITCH  = 16'd1920;

	typedef struct packed {
		logic [31:0] base;
		logic [12:0] sw;
		logic [12:0] sh;
		logic [15:0] pitch;
	} cfg_t;

	typedef struct packed {
		logic        tick;
		logic        empty;
		logic        walk;
		logic [13:0] bytes;
		logic [31:0] src;
		logic [31:0] dst;
	} ent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic emit;
		logic last;
		logic idle;
	} bk_stat_t;

endpackage
`default_nettype wire

### sv/crbrg_front.sv
`default_nettype none
module crbrg_front #(
	parameter int MAX_DIM = crbrg_pkg::MAX_DIM_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             acc,
	input  logic                             action,
	input  logic signed [12:0]               source_x,
	input  logic signed [12:0]               source_y,
	input  logic signed [12:0]               target_x,
	input  logic signed [12:0]               target_y,
	input  logic        [12:0]               rect_width,
	input  logic        [12:0]               rect_height,
	input  crbrg_pkg::cfg_t                  cfg,
	output logic                             push,
	output crbrg_pkg::ent_t                  ent,
	output logic [$clog2(MAX_DIM+1)-1:0]     rows
);
	import crbrg_pkg::*;

	localparam int RW = $clog2(MAX_DIM + 1);
	localparam logic signed [CW-1:0] MAXC = CW'(MAX_DIM);

	typedef struct packed {
		logic signed [CW-1:0] s;
		logic signed [CW-1:0] d;
		logic signed [CW-1:0] len;
	} axis_t;

	function automatic axis_t clip_origin(input logic signed [CW-1:0] s,
			input logic signed [CW-1:0] d, input logic signed [CW-1:0] len);
		axis_t r;
		r.s   = s;
		r.d   = d;
		r.len = len;
		if (r.s < 0) begin
			r.len = r.len + r.s;
			r.d   = r.d - r.s;
			r.s   = '0;
		end
		if (r.d < 0) begin
			r.len = r.len + r.d;
			r.s   = r.s - r.d;
			r.d   = '0;
		end
		return r;
	endfunction

	function automatic logic signed [CW-1:0] min2(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	axis_t ax, ay;
	logic signed [CW-1:0] sw_c, sh_c, wmin, hmin;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic tick_s1, tick_s2, tick_s3, tick_s4, tick_s5;
	logic signed [CW-1:0] sx_s1, sy_s1, dx_s1, dy_s1, w_s1, h_s1;
	logic signed [CW-1:0] sx_s2, sy_s2, dx_s2, dy_s2, w_s2, h_s2;
	logic walk_s2, walk_s3, walk_s4, walk_s5;
	logic empty_s2, empty_s3, empty_s4, empty_s5;
	logic [CW-1:0] ys_s3, yd_s3;
	logic [31:0] xs_s3, xd_s3;
	logic [13:0] bytes_s3, bytes_s4, bytes_s5;
	logic [RW-1:0] rows_s3, rows_s4, rows_s5;
	logic [31:0] prs_s4, prd_s4, ofs_s4, ofd_s4;
	logic [31:0] src_s5, dst_s5;

	always_comb begin
		ax   = clip_origin(CW'(source_x), CW'(target_x), CW'(rect_width));
		ay   = clip_origin(CW'(source_y), CW'(target_y), CW'(rect_height));
		sw_c = CW'(cfg.sw);
		sh_c = CW'(cfg.sh);
		wmin = min2(min2(w_s1, sw_c - sx_s1), min2(sw_c - dx_s1, MAXC));
		hmin = min2(min2(h_s1, sh_c - sy_s1), min2(sh_c - dy_s1, MAXC));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		tick_s1 <= action;
		sx_s1   <= ax.s;
		dx_s1   <= ax.d;
		w_s1    <= ax.len;
		sy_s1   <= ay.s;
		dy_s1   <= ay.d;
		h_s1    <= ay.len;

		tick_s2  <= tick_s1;
		sx_s2    <= sx_s1;
		sy_s2    <= sy_s1;
		dx_s2    <= dx_s1;
		dy_s2    <= dy_s1;
		w_s2     <= wmin;
		h_s2     <= hmin;
		walk_s2  <= dy_s1 > sy_s1;
		empty_s2 <= (wmin <= 0) || (hmin <= 0);

		tick_s3  <= tick_s2;
		walk_s3  <= walk_s2;
		empty_s3 <= empty_s2;
		ys_s3    <= walk_s2 ? sy_s2 + h_s2 - CW'(1) : sy_s2;
		yd_s3    <= walk_s2 ? dy_s2 + h_s2 - CW'(1) : dy_s2;
		xs_s3    <= 32'(sx_s2) * 32'd3;
		xd_s3    <= 32'(dx_s2) * 32'd3;
		bytes_s3 <= 14'(w_s2 * 16'sd3);
		rows_s3  <= h_s2[RW-1:0];

		tick_s4  <= tick_s3;
		walk_s4  <= walk_s3;
		empty_s4 <= empty_s3;
		bytes_s4 <= bytes_s3;
		rows_s4  <= rows_s3;
		prs_s4   <= 32'(ys_s3) * 32'(cfg.pitch);
		prd_s4   <= 32'(yd_s3) * 32'(cfg.pitch);
		ofs_s4   <= cfg.base + xs_s3;
		ofd_s4   <= cfg.base + xd_s3;

		tick_s5  <= tick_s4;
		walk_s5  <= walk_s4;
		empty_s5 <= empty_s4;
		bytes_s5 <= bytes_s4;
		rows_s5  <= rows_s4;
		src_s5   <= prs_s4 + ofs_s4;
		dst_s5   <= prd_s4 + ofd_s4;
	end

	always_comb begin
		push      = v_s5;
		ent.tick  = tick_s5;
		ent.empty = empty_s5;
		ent.walk  = walk_s5;
		ent.bytes = bytes_s5;
		ent.src   = src_s5;
		ent.dst   = dst_s5;
		rows      = rows_s5;
	end

endmodule
`default_nettype wire

### sv/crbrg_queue.sv
`default_nettype none
module crbrg_queue #(
	parameter int W     = 8,
	parameter int DEPTH = crbrg_pkg::Q_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [W-1:0]        wdata,
	input  logic                pop,
	output logic [W-1:0]        rdata,
	output crbrg_pkg::q_stat_t  stat
);
	import crbrg_pkg::*;

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0]    mem_q [DEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [CNTW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			cnt_q <= cnt_q + CNTW'(push) - CNTW'(pop);
		end
	end

	assign rdata      = mem_q[rp_q];
	assign stat.full  = cnt_q == CNTW'(DEPTH);
	assign stat.empty = cnt_q == '0;

endmodule
`default_nettype wire

### sv/crbrg_back.sv
`default_nettype none
module crbrg_back #(
	parameter int MAX_DIM = crbrg_pkg::MAX_DIM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  crbrg_pkg::ent_t                q_ent,
	input  logic [$clog2(MAX_DIM+1)-1:0]   q_rows,
	input  logic                           q_valid,
	input  logic [15:0]                    pitch,
	input  logic                           ready,
	output logic                           pop,
	output logic                           valid,
	output logic [31:0]                    source_address,
	output logic [31:0]                    target_address,
	output logic [13:0]                    byte_count,
	output logic                           last_row,
	output crbrg_pkg::bk_stat_t            stat
);
	import crbrg_pkg::*;

	localparam int RW = $clog2(MAX_DIM + 1);

	logic [RW-1:0] rows_q;
	logic [31:0]   src_q, dst_q;
	logic [13:0]   bytes_q;
	logic          walk_q;
	logic          out_valid_q, out_last_q;
	logic [31:0]   out_src_q, out_dst_q;
	logic [13:0]   out_bytes_q;
	logic          out_free, emit, load;

	assign out_free = !out_valid_q || ready;
	assign pop      = q_valid && (!q_ent.tick || out_free);
	assign load     = pop && !q_ent.tick;
	assign emit     = pop && q_ent.tick && (rows_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q      <= '0;
			walk_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				rows_q <= q_ent.empty ? '0 : q_rows;
				walk_q <= q_ent.walk;
			end else if (emit) begin
				rows_q <= rows_q - RW'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			src_q   <= q_ent.src;
			dst_q   <= q_ent.dst;
			bytes_q <= q_ent.bytes;
		end else if (emit) begin
			src_q <= walk_q ? src_q - 32'(pitch) : src_q + 32'(pitch);
			dst_q <= walk_q ? dst_q - 32'(pitch) : dst_q + 32'(pitch);
		end
		if (emit) begin
			out_src_q   <= src_q;
			out_dst_q   <= dst_q;
			out_bytes_q <= bytes_q;
			out_last_q  <= rows_q == RW'(1);
		end
	end

	assign valid          = out_valid_q;
	assign source_address = out_src_q;
	assign target_address = out_dst_q;
	assign byte_count     = out_bytes_q;
	assign last_row       = out_last_q;
	assign stat.emit      = emit;
	assign stat.last      = rows_q == RW'(1);
	assign stat.idle      = rows_q == '0;

endmodule
`default_nettype wire

### sv/clipped_rect_blit_row_generator_unit.sv
// Row address generator for a 24 bpp screen-to-screen rectangle copy.
// Input channel (in_valid/in_ready): action 0 is a copy command with source and
// target origins and rectangle size; action 1 is a tick asking for the next row.
// Output channel (out_valid/out_ready): one word per tick while rows remain, with
// source and target byte addresses, byte count and a last-row flag. A command
// produces no word and replaces any copy still pending; a tick with none pending
// produces nothing.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0 base, 1 screen
// width, 2 screen height, 3 line pitch; write only while idle.
// Path: a tick passes the five-stage clip and address pipeline, the queue and the
// output register. Throughput: one word per cycle while ticks arrive and out_ready
// holds; the back end steps the row addresses by the pitch (down when walking) for
// each word, and an 8-entry credited queue covers the pipeline round trip.
// Reset: registers take 640x480, pitch 1920, base 0; no copy pending.
// When the receiver stalls the output word holds, the queue fills, and in_ready
// falls once all queue credits are in use.
`default_nettype none
`include "clipped_rect_blit_row_generator_unit_assert.svh"
module clipped_rect_blit_row_generator_unit #(
	parameter int MAX_DIM = crbrg_pkg::MAX_DIM_DEF,
	parameter int Q_DEPTH = crbrg_pkg::Q_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                action,
	input  logic signed [12:0]                  source_x,
	input  logic signed [12:0]                  source_y,
	input  logic signed [12:0]                  target_x,
	input  logic signed [12:0]                  target_y,
	input  logic        [12:0]                  rect_width,
	input  logic        [12:0]                  rect_height,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic        [31:0]                  source_address,
	output logic        [31:0]                  target_address,
	output logic        [13:0]                  byte_count,
	output logic                                last_row,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [crbrg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic        [31:0]                  cfg_data
);
	import crbrg_pkg::*;

	localparam int RW  = $clog2(MAX_DIM + 1);
	localparam int CRW = $clog2(Q_DEPTH + 1);
	localparam int QW  = RW + $bits(ent_t);

	cfg_t          cfg_q;
	logic [CRW-1:0] credit_q;
	logic          in_acc, f_push, q_pop;
	ent_t          f_ent, q_ent;
	logic [RW-1:0] f_rows, q_rows;
	logic [QW-1:0] q_rdata;
	q_stat_t       q_stat;
	bk_stat_t      bk_stat;

	assign cfg_ready = 1'b1;
	assign in_ready  = credit_q != '0;
	assign in_acc    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base  <= RST_BASE;
			cfg_q.sw    <= RST_WIDTH;
			cfg_q.sh    <= RST_HEIGHT;
			cfg_q.pitch <= RST_PITCH;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BASE:   cfg_q.base  <= cfg_data;
				CFG_WIDTH:  cfg_q.sw    <= cfg_data[12:0];
				CFG_HEIGHT: cfg_q.sh    <= cfg_data[12:0];
				CFG_PITCH:  cfg_q.pitch <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CRW'(Q_DEPTH);
		end else begin
			credit_q <= credit_q + CRW'(q_pop) - CRW'(in_acc);
		end
	end

	crbrg_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.acc(in_acc),
		.action(action),
		.source_x(source_x),
		.source_y(source_y),
		.target_x(target_x),
		.target_y(target_y),
		.rect_width(rect_width),
		.rect_height(rect_height),
		.cfg(cfg_q),
		.push(f_push),
		.ent(f_ent),
		.rows(f_rows)
	);

	crbrg_queue #(.W(QW), .DEPTH(Q_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(f_push),
		.wdata({f_rows, f_ent}),
		.pop(q_pop),
		.rdata(q_rdata),
		.stat(q_stat)
	);

	assign q_rows = q_rdata[QW-1 -: RW];
	assign q_ent  = q_rdata[$bits(ent_t)-1:0];

	crbrg_back #(.MAX_DIM(MAX_DIM)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_ent(q_ent),
		.q_rows(q_rows),
		.q_valid(!q_stat.empty),
		.pitch(cfg_q.pitch),
		.ready(out_ready),
		.pop(q_pop),
		.valid(out_valid),
		.source_address(source_address),
		.target_address(target_address),
		.byte_count(byte_count),
		.last_row(last_row),
		.stat(bk_stat)
	);

	`CRBRG_ASSERT_ALWAYS(a_credit_bound, clk, arst_n, credit_q <= CRW'(Q_DEPTH))
	`CRBRG_ASSERT_IMPLY(a_no_push_full, clk, arst_n, f_push, !q_stat.full || q_pop)
	`CRBRG_ASSERT_NEXT(a_last_idle, clk, arst_n, bk_stat.emit && bk_stat.last, bk_stat.idle)

endmodule
`default_nettype wire
